// File: design/bleadv_pkg.sv
// Shared types, status codes and byte offsets for the advertisement parser.
package bleadv_pkg;

   // Result status codes
   localparam logic [2:0] ST_OK          = 3'd0;
   localparam logic [2:0] ST_TOO_SHORT   = 3'd1;
   localparam logic [2:0] ST_FLAGS_LEN   = 3'd2;
   localparam logic [2:0] ST_FLAGS_TYPE  = 3'd3;
   localparam logic [2:0] ST_NOT_MFR     = 3'd4;
   localparam logic [2:0] ST_WRONG_ID    = 3'd5;
   localparam logic [2:0] ST_MD_LENGTH   = 3'd6;
   localparam logic [2:0] ST_SHORT_PAYLD = 3'd7;

   // Frame layout
   localparam int HEADER_BYTES      = 7;
   localparam int MIN_PAYLOAD_BYTES = 24;

   localparam logic [7:0] OFF_FLAGS_LEN  = 8'd0;
   localparam logic [7:0] OFF_FLAGS_TYPE = 8'd1;
   localparam logic [7:0] OFF_MD_LEN     = 8'd3;
   localparam logic [7:0] OFF_MD_TYPE    = 8'd4;
   localparam logic [7:0] OFF_ID_LOW     = 8'd5;
   localparam logic [7:0] OFF_ID_HIGH    = 8'd6;
   localparam logic [7:0] OFF_TEMP_HI    = 8'd8;
   localparam logic [7:0] OFF_TEMP_LO    = 8'd9;
   localparam logic [7:0] OFF_HUM_HI     = 8'd10;
   localparam logic [7:0] OFF_HUM_LO     = 8'd11;
   localparam logic [7:0] OFF_PRES_HI    = 8'd12;
   localparam logic [7:0] OFF_PRES_LO    = 8'd13;
   localparam logic [7:0] OFF_PWR_HI     = 8'd20;
   localparam logic [7:0] OFF_PWR_LO     = 8'd21;

   // Expected header byte values
   localparam logic [7:0] FLAGS_LEN_VAL  = 8'h02;
   localparam logic [7:0] FLAGS_TYPE_VAL = 8'h01;
   localparam logic [7:0] MD_TYPE_VAL    = 8'hff;
   localparam logic [7:0] POS_MAX        = 8'hff;

   localparam logic [15:0] MFR_ID_RESET  = 16'h0499;

   // Reading offsets
   localparam logic [16:0] PRESSURE_OFFSET = 17'd50000;
   localparam logic [11:0] BATTERY_OFFSET  = 12'd1600;

   // Frame state as seen after the current byte
   typedef struct packed {
      logic [7:0]  pos;
      logic [2:0]  hdr_err;
      logic [7:0]  md_len;
      logic [15:0] temp;
      logic [15:0] hum;
      logic [15:0] pres;
      logic [15:0] pwr;
   } frame_type;

endpackage

// File: design/bleadv_if.sv
// Valid/ready channel interfaces for advertisement bytes and parse results.
interface bleadv_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] ad_byte;
   logic       last_byte;

   modport source (output valid, output ad_byte, output last_byte, input ready);
   modport sink   (input valid, input ad_byte, input last_byte, output ready);
endinterface

interface bleadv_rsp_if;
   logic               valid;
   logic               ready;
   logic [2:0]         status;
   logic signed [15:0] temperature_raw;
   logic [15:0]        humidity_raw;
   logic [16:0]        pressure_pa;
   logic [11:0]        battery_mv;

   modport source (output valid, output status, output temperature_raw,
                   output humidity_raw, output pressure_pa, output battery_mv,
                   input ready);
   modport sink   (input valid, input status, input temperature_raw,
                   input humidity_raw, input pressure_pa, input battery_mv,
                   output ready);
endinterface

// File: design/bleadv_frame.sv
// Byte counter, header checks and sensor word capture for one advertisement.
module bleadv_frame (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 accept,
   input  logic [7:0]           ad_byte,
   input  logic                 last_byte,
   input  logic [15:0]          mfr_id,
   output bleadv_pkg::frame_type frame_nxt
);
   import bleadv_pkg::*;

   frame_type  frame_ff;
   frame_type  frame_in;
   logic [7:0] id_low_ff;
   logic [7:0] id_low_in;

   // Frame state after the incoming byte
   always_comb begin
      frame_nxt = frame_ff;
      id_low_in = id_low_ff;
      if (frame_ff.pos != POS_MAX) begin
         case (frame_ff.pos)
            OFF_FLAGS_LEN: begin
               if (ad_byte != FLAGS_LEN_VAL && frame_ff.hdr_err == ST_OK)
                  frame_nxt.hdr_err = ST_FLAGS_LEN;
            end
            OFF_FLAGS_TYPE: begin
               if (ad_byte != FLAGS_TYPE_VAL && frame_ff.hdr_err == ST_OK)
                  frame_nxt.hdr_err = ST_FLAGS_TYPE;
            end
            OFF_MD_LEN:  frame_nxt.md_len = ad_byte;
            OFF_MD_TYPE: begin
               if (ad_byte != MD_TYPE_VAL && frame_ff.hdr_err == ST_OK)
                  frame_nxt.hdr_err = ST_NOT_MFR;
            end
            OFF_ID_LOW:  id_low_in = ad_byte;
            OFF_ID_HIGH: begin
               if ({ad_byte, id_low_ff} != mfr_id && frame_ff.hdr_err == ST_OK)
                  frame_nxt.hdr_err = ST_WRONG_ID;
            end
            OFF_TEMP_HI: frame_nxt.temp[15:8] = ad_byte;
            OFF_TEMP_LO: frame_nxt.temp[7:0]  = ad_byte;
            OFF_HUM_HI:  frame_nxt.hum[15:8]  = ad_byte;
            OFF_HUM_LO:  frame_nxt.hum[7:0]   = ad_byte;
            OFF_PRES_HI: frame_nxt.pres[15:8] = ad_byte;
            OFF_PRES_LO: frame_nxt.pres[7:0]  = ad_byte;
            OFF_PWR_HI:  frame_nxt.pwr[15:8]  = ad_byte;
            OFF_PWR_LO:  frame_nxt.pwr[7:0]   = ad_byte;
            default: ;
         endcase
         frame_nxt.pos = frame_ff.pos + 8'd1;
      end
   end

   // Last byte ends the frame and clears the state
   always_comb begin
      frame_in = frame_ff;
      if (accept) begin
         frame_in = last_byte ? '0 : frame_nxt;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_ff  <= '0;
         id_low_ff <= '0;
      end else if (accept) begin
         frame_ff  <= frame_in;
         id_low_ff <= last_byte ? 8'd0 : id_low_in;
      end
   end

endmodule

// File: design/bleadv_result.sv
// Status decision, reading scaling and output register of the parser.
module bleadv_result #(
   parameter int MIN_PAYLOAD = bleadv_pkg::MIN_PAYLOAD_BYTES
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 load,
   input  bleadv_pkg::frame_type frame,
   bleadv_rsp_if.source         rsp_bus
);
   import bleadv_pkg::*;

   localparam logic [7:0] MIN_LEN = 8'(MIN_PAYLOAD + HEADER_BYTES);
   localparam logic [7:0] HDR_LEN = 8'(HEADER_BYTES);

   logic               valid_ff;
   logic [2:0]         status_ff, status_in;
   logic signed [15:0] temp_ff, temp_in;
   logic [15:0]        hum_ff, hum_in;
   logic [16:0]        pres_ff, pres_in;
   logic [11:0]        batt_ff, batt_in;
   logic [8:0]         md_end;

   // Checks in priority order
   always_comb begin
      md_end = {1'b0, frame.md_len} + 9'd4;
      if (frame.pos < HDR_LEN)
         status_in = ST_TOO_SHORT;
      else if (frame.hdr_err != ST_OK)
         status_in = frame.hdr_err;
      else if (frame.md_len >= 8'd3 && {1'b0, frame.pos} < md_end)
         status_in = ST_MD_LENGTH;
      else if (frame.pos < MIN_LEN)
         status_in = ST_SHORT_PAYLD;
      else
         status_in = ST_OK;
   end

   // Readings are zero on any failure
   always_comb begin
      temp_in = '0;
      hum_in  = '0;
      pres_in = '0;
      batt_in = '0;
      if (status_in == ST_OK) begin
         temp_in = signed'(frame.temp);
         hum_in  = frame.hum;
         pres_in = {1'b0, frame.pres} + PRESSURE_OFFSET;
         batt_in = {1'b0, frame.pwr[15:5]} + BATTERY_OFFSET;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (load) begin
         valid_ff <= 1'b1;
      end else if (rsp_bus.ready) begin
         valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         status_ff <= status_in;
         temp_ff   <= temp_in;
         hum_ff    <= hum_in;
         pres_ff   <= pres_in;
         batt_ff   <= batt_in;
      end
   end

   assign rsp_bus.valid           = valid_ff;
   assign rsp_bus.status          = status_ff;
   assign rsp_bus.temperature_raw = temp_ff;
   assign rsp_bus.humidity_raw    = hum_ff;
   assign rsp_bus.pressure_pa     = pres_ff;
   assign rsp_bus.battery_mv      = batt_ff;

endmodule

// File: design/ble_sensor_adv_parser.sv
// Top level of the advertisement sensor parser.
//
// Usage:
//   req_bus carries one advertisement byte per item (ad_byte) with last_byte
//   set on the final byte. rsp_bus carries one item per advertisement:
//   status plus temperature, humidity, pressure and battery readings
//   (readings are zero unless status is ok).
//   csr_wr_en/csr_wr_data write the expected company id; write only while
//   no advertisement is in progress and no result is pending.
// Timing:
//   One byte is taken per cycle while req_bus.ready is high. The result
//   appears in the output register the cycle after the last byte is accepted.
//   Each byte passes through one update of the frame state registers.
// Reset:
//   Frame state clears, no result is pending, company id returns to 0x0499.
// Stall:
//   While a result waits and rsp_bus.ready is low, req_bus.ready drops;
//   the result register holds. When the result is taken in the same cycle,
//   the next byte is still accepted.
module ble_sensor_adv_parser #(
   parameter int MIN_PAYLOAD = bleadv_pkg::MIN_PAYLOAD_BYTES
) (
   input  logic          clock,
   input  logic          reset,
   bleadv_req_if.sink    req_bus,
   bleadv_rsp_if.source  rsp_bus,
   input  logic          csr_wr_en,
   input  logic [15:0]   csr_wr_data
);
   import bleadv_pkg::*;

   logic [15:0] mfr_id_ff;
   logic        accept;
   frame_type   frame_nxt;

   // Company id register
   always_ff @(posedge clock) begin
      if (reset) begin
         mfr_id_ff <= MFR_ID_RESET;
      end else if (csr_wr_en) begin
         mfr_id_ff <= csr_wr_data;
      end
   end

   // Take a byte when the output register is free or being drained
   assign req_bus.ready = !rsp_bus.valid || rsp_bus.ready;
   assign accept        = req_bus.valid && req_bus.ready;

   bleadv_frame u_frame (
      .clock     (clock),
      .reset     (reset),
      .accept    (accept),
      .ad_byte   (req_bus.ad_byte),
      .last_byte (req_bus.last_byte),
      .mfr_id    (mfr_id_ff),
      .frame_nxt (frame_nxt)
   );

   bleadv_result #(
      .MIN_PAYLOAD (MIN_PAYLOAD)
   ) u_result (
      .clock   (clock),
      .reset   (reset),
      .load    (accept && req_bus.last_byte),
      .frame   (frame_nxt),
      .rsp_bus (rsp_bus)
   );

endmodule

// File: design/bleadv_checker.sv
// Port-level checks for the advertisement parser, bound to the top level.
module bleadv_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic        req_last,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [2:0]  rsp_status,
   input logic [15:0] rsp_temp,
   input logic [15:0] rsp_hum,
   input logic [16:0] rsp_pres,
   input logic [11:0] rsp_batt
);
   import bleadv_pkg::*;

   // A pending result stays until taken
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result dropped while stalled");

   // Last byte produces a result next cycle
   a_last_rsp: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_last |=> rsp_valid)
      else $error("no result after last byte");

   // Empty output register means bytes are taken
   a_ready: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("input stalled with empty output");

   // Failed frames carry zero readings
   a_fail_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != ST_OK |->
         rsp_temp == '0 && rsp_hum == '0 && rsp_pres == '0 && rsp_batt == '0)
      else $error("readings nonzero on failed frame");

   // Good frames carry offset readings
   a_ok_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == ST_OK |->
         rsp_pres >= PRESSURE_OFFSET && rsp_batt >= BATTERY_OFFSET)
      else $error("reading below its offset");

endmodule

bind ble_sensor_adv_parser bleadv_checker u_checker (
   .clock      (clock),
   .reset      (reset),
   .req_valid  (req_bus.valid),
   .req_ready  (req_bus.ready),
   .req_last   (req_bus.last_byte),
   .rsp_valid  (rsp_bus.valid),
   .rsp_ready  (rsp_bus.ready),
   .rsp_status (rsp_bus.status),
   .rsp_temp   (rsp_bus.temperature_raw),
   .rsp_hum    (rsp_bus.humidity_raw),
   .rsp_pres   (rsp_bus.pressure_pa),
   .rsp_batt   (rsp_bus.battery_mv)
);

// File: sim/ble_sensor_adv_parser_tb.sv
// Self-checking testbench for the advertisement sensor parser: byte stimulus, predictor, checker.
module ble_sensor_adv_parser_tb;
   import bleadv_pkg::*;

   localparam int STALL_LIMIT   = 2000;  // cycles with no accepted item before giving up
   localparam int SETTLE_CYCLES = 4;     // margin after the last result is taken
   localparam int RANDOM_ITEMS  = 120;
   localparam int RANDOM_FRAMES = 4;

   // One parse result as seen on the response channel
   typedef struct packed {
      logic [2:0]         status;
      logic signed [15:0] temperature;
      logic [15:0]        humidity;
      logic [16:0]        pressure;
      logic [11:0]        battery;
   } adv_result_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        csr_wr_en;
   logic [15:0] csr_wr_data;

   bleadv_req_if req_bus ();
   bleadv_rsp_if rsp_bus ();

   ble_sensor_adv_parser u_top (
      .clock       (clock),
      .reset       (reset),
      .req_bus     (req_bus),
      .rsp_bus     (rsp_bus),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   always #1 clock = ~clock;

   // Predicted results, oldest first
   adv_result_type expected_results[$];

   // Predictor copy of the block state
   logic [15:0] pred_company_id;
   logic [7:0]  pred_pos;
   logic [2:0]  pred_hdr_err;
   logic [7:0]  pred_md_len;
   logic [7:0]  pred_id_low;
   logic [15:0] pred_temp;
   logic [15:0] pred_hum;
   logic [15:0] pred_pres;
   logic [15:0] pred_pwr;

   // Stimulus side
   logic [7:0]  adv_buf[$];
   logic [15:0] frame_id;
   bit          send_gaps_on;
   bit          recv_gaps_on;
   int          recv_stall_left;
   int          results_seen;
   int          fail_count;
   int          idle_cycles;

   // Gap length: mostly none or short, now and then long
   function automatic int pick_gap(input bit enabled);
      int r;
      r = $urandom_range(0, 99);
      if (!enabled || r < 50) return 0;
      if (r < 88) return $urandom_range(1, 3);
      return $urandom_range(6, 40);
   endfunction

   task automatic clear_frame_state();
      pred_pos     = '0;
      pred_hdr_err = ST_OK;
      pred_md_len  = '0;
      pred_id_low  = '0;
      pred_temp    = '0;
      pred_hum     = '0;
      pred_pres    = '0;
      pred_pwr     = '0;
   endtask

   // Only the first failing header check is kept
   task automatic note_header_fault(input logic [2:0] code);
      if (pred_hdr_err == ST_OK) pred_hdr_err = code;
   endtask

   // Advance the predicted frame state by one byte; on the last byte queue the result
   task automatic parse_byte(input logic [7:0] b, input logic last);
      adv_result_type res;
      int             len;
      if (pred_pos != POS_MAX) begin
         case (pred_pos)
            OFF_FLAGS_LEN: begin
               if (b != FLAGS_LEN_VAL) note_header_fault(ST_FLAGS_LEN);
            end
            OFF_FLAGS_TYPE: begin
               if (b != FLAGS_TYPE_VAL) note_header_fault(ST_FLAGS_TYPE);
            end
            OFF_MD_LEN: pred_md_len = b;
            OFF_MD_TYPE: begin
               if (b != MD_TYPE_VAL) note_header_fault(ST_NOT_MFR);
            end
            OFF_ID_LOW: pred_id_low = b;
            OFF_ID_HIGH: begin
               if ({b, pred_id_low} != pred_company_id) note_header_fault(ST_WRONG_ID);
            end
            OFF_TEMP_HI: pred_temp[15:8] = b;
            OFF_TEMP_LO: pred_temp[7:0]  = b;
            OFF_HUM_HI:  pred_hum[15:8]  = b;
            OFF_HUM_LO:  pred_hum[7:0]   = b;
            OFF_PRES_HI: pred_pres[15:8] = b;
            OFF_PRES_LO: pred_pres[7:0]  = b;
            OFF_PWR_HI:  pred_pwr[15:8]  = b;
            OFF_PWR_LO:  pred_pwr[7:0]   = b;
            default: ;
         endcase
         pred_pos = pred_pos + 8'd1;
      end
      if (last) begin
         len = int'(pred_pos);
         res = '0;
         if (len < HEADER_BYTES)
            res.status = ST_TOO_SHORT;
         else if (pred_hdr_err != ST_OK)
            res.status = pred_hdr_err;
         else if (pred_md_len >= 8'd3 && len < int'(pred_md_len) + 4)
            res.status = ST_MD_LENGTH;
         else if (len - HEADER_BYTES < MIN_PAYLOAD_BYTES)
            res.status = ST_SHORT_PAYLD;
         else
            res.status = ST_OK;
         if (res.status == ST_OK) begin
            res.temperature = pred_temp;
            res.humidity    = pred_hum;
            res.pressure    = {1'b0, pred_pres} + PRESSURE_OFFSET;
            res.battery     = {1'b0, pred_pwr[15:5]} + BATTERY_OFFSET;
         end
         expected_results.push_back(res);
         clear_frame_state();
      end
   endtask

   // Predictor: follows register writes and accepted bytes
   always @(posedge clock) begin
      if (reset) begin
         pred_company_id = MFR_ID_RESET;
         clear_frame_state();
      end else begin
         if (csr_wr_en) pred_company_id = csr_wr_data;
         if (req_bus.valid && req_bus.ready) parse_byte(req_bus.ad_byte, req_bus.last_byte);
      end
   end

   task automatic check_field(input string name, input logic [16:0] want,
                              input logic [16:0] got);
      if (want !== got) begin
         $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
         fail_count++;
      end
   endtask

   // Result checker
   always @(posedge clock) begin : check_result
      adv_result_type want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         results_seen++;
         if (expected_results.size() == 0) begin
            $display("%0t: unexpected result, expected none, actual status %0d",
                     $time, rsp_bus.status);
            fail_count++;
         end else begin
            want = expected_results.pop_front();
            check_field("status", 17'(want.status), 17'(rsp_bus.status));
            check_field("temperature_raw", 17'(want.temperature),
                        17'(rsp_bus.temperature_raw));
            check_field("humidity_raw", 17'(want.humidity), 17'(rsp_bus.humidity_raw));
            check_field("pressure_pa", want.pressure, rsp_bus.pressure_pa);
            check_field("battery_mv", 17'(want.battery), 17'(rsp_bus.battery_mv));
         end
      end
   end

   // Result channel back-pressure
   always @(posedge clock) begin
      if (reset) begin
         rsp_bus.ready   <= 1'b0;
         recv_stall_left = 0;
      end else if (recv_stall_left > 0) begin
         rsp_bus.ready   <= 1'b0;
         recv_stall_left = recv_stall_left - 1;
      end else begin
         rsp_bus.ready <= 1'b1;
         if ($urandom_range(0, 3) == 0) recv_stall_left = pick_gap(recv_gaps_on);
      end
   end

   // Watchdog: cycles in which no item moves on either channel
   always @(posedge clock) begin
      if (reset)
         idle_cycles <= 0;
      else if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
   end

   initial begin : watchdog
      @(negedge reset);
      while (idle_cycles < STALL_LIMIT) @(posedge clock);
      $display("status: fail");
      $finish;
   end

   // Send one byte item; valid stays high across back-to-back items
   task automatic push_byte(input logic [7:0] b, input logic last);
      int gap;
      gap = pick_gap(send_gaps_on);
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_bus.valid     <= 1'b1;
      req_bus.ad_byte   <= b;
      req_bus.last_byte <= last;
      do @(posedge clock); while (!req_bus.ready);
   endtask

   task automatic send_adv();
      foreach (adv_buf[i]) push_byte(adv_buf[i], i == adv_buf.size() - 1);
   endtask

   // Stop sending and wait until every predicted result has been taken
   task automatic wait_idle();
      req_bus.valid <= 1'b0;
      @(posedge clock);
      while (expected_results.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_company_id(input logic [15:0] id);
      wait_idle();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= id;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      frame_id  = id;
   endtask

   // Fill adv_buf with a well-formed advertisement of len bytes
   task automatic build_adv(input int len, input logic [15:0] id, input logic [15:0] t,
                            input logic [15:0] h, input logic [15:0] p,
                            input logic [15:0] w);
      logic [7:0] b;
      adv_buf.delete();
      for (int i = 0; i < len; i++) begin
         case (i)
            0:  b = FLAGS_LEN_VAL;
            1:  b = FLAGS_TYPE_VAL;
            3:  b = 8'(len - 4);
            4:  b = MD_TYPE_VAL;
            5:  b = id[7:0];
            6:  b = id[15:8];
            8:  b = t[15:8];
            9:  b = t[7:0];
            10: b = h[15:8];
            11: b = h[7:0];
            12: b = p[15:8];
            13: b = p[7:0];
            20: b = w[15:8];
            21: b = w[7:0];
            default: b = 8'($urandom);
         endcase
         adv_buf.push_back(b);
      end
   endtask

   task automatic build_random_adv(input int len);
      build_adv(len, frame_id, 16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
   endtask

   // Readings at their extremes on good frames at and just above minimum length
   task automatic test_sensor_readings();
      send_gaps_on = 1'b0;
      recv_gaps_on = 1'b0;
      build_adv(31, frame_id, 16'h8000, 16'h0000, 16'h0000, 16'h0000);
      send_adv();
      build_adv(31, frame_id, 16'h7fff, 16'hffff, 16'hffff, 16'hffff);
      send_adv();
      send_gaps_on = 1'b1;
      recv_gaps_on = 1'b1;
      build_adv(32, frame_id, 16'hffff, 16'h8000, 16'h8000, 16'h001f);
      send_adv();
      build_adv(33, frame_id, 16'h0000, 16'h0001, 16'h0001, 16'hffe0);
      send_adv();
   endtask

   // Each header check, and the order among them
   task automatic test_header_checks();
      send_gaps_on = 1'b1;
      recv_gaps_on = 1'b1;
      // flags length, flags type, manufacturer type, id low, id high
      build_random_adv(8); adv_buf[0] = 8'h03;          send_adv();
      build_random_adv(8); adv_buf[1] = 8'h00;          send_adv();
      build_random_adv(8); adv_buf[4] = 8'h16;          send_adv();
      build_random_adv(8); adv_buf[5] = ~adv_buf[5];    send_adv();
      build_random_adv(8); adv_buf[6] = ~adv_buf[6];    send_adv();
      // first failing check wins
      build_random_adv(8); adv_buf[1] = 8'h00; adv_buf[4] = 8'h00; send_adv();
      build_random_adv(8); adv_buf[0] = 8'h00; adv_buf[6] = ~adv_buf[6]; send_adv();
      // declared length one past the frame, then small declared lengths below and at the smallest one checked
      build_random_adv(31); adv_buf[3] = 8'd28;          send_adv();
      build_random_adv(31); adv_buf[3] = 8'd2;           send_adv();
      build_random_adv(31); adv_buf[3] = 8'd0;           send_adv();
      build_random_adv(31); adv_buf[3] = 8'd3;           send_adv();
      // header fault outranks md length
      build_random_adv(8); adv_buf[3] = 8'd200; adv_buf[4] = 8'h00; send_adv();
      // payload one byte short, and a frame of header only
      build_random_adv(30);                              send_adv();
      build_random_adv(7);                               send_adv();
      // too short outranks any header fault
      build_random_adv(6);                               send_adv();
      build_random_adv(1); adv_buf[0] = 8'h00;           send_adv();
      build_random_adv(1);                               send_adv();
   endtask

   // Byte count saturation on a long frame
   task automatic test_length_limits();
      send_gaps_on = 1'b0;
      recv_gaps_on = 1'b1;
      // declared length is met only by a count that runs past 255
      build_random_adv(256);                       send_adv();
   endtask

   // Company id register at its extremes and back to its reset value
   task automatic test_company_id();
      send_gaps_on = 1'b1;
      recv_gaps_on = 1'b1;
      write_company_id(16'h0000);
      build_random_adv(31); send_adv();
      build_adv(31, MFR_ID_RESET, 16'h1234, 16'h5678, 16'h9abc, 16'hdef0); send_adv();
      write_company_id(16'hffff);
      build_random_adv(31); send_adv();
      write_company_id(16'($urandom));
      build_random_adv(34); send_adv();
      write_company_id(MFR_ID_RESET);
      build_random_adv(31); send_adv();
   endtask

   // Mostly well-formed frames with random content, some broken ones and noise
   task automatic test_random_traffic();
      int items_sent;
      int frames_start;
      int kind;
      int len;
      int k;
      items_sent   = 0;
      frames_start = results_seen;
      while (items_sent < RANDOM_ITEMS || results_seen - frames_start < RANDOM_FRAMES) begin
         send_gaps_on = ($urandom_range(0, 3) != 0);
         recv_gaps_on = ($urandom_range(0, 3) != 0);
         if ($urandom_range(0, 11) == 0) begin
            k = $urandom_range(0, 3);
            case (k)
               0: write_company_id(16'h0000);
               1: write_company_id(16'hffff);
               2: write_company_id(MFR_ID_RESET);
               default: write_company_id(16'($urandom));
            endcase
         end
         kind = $urandom_range(0, 99);
         if (kind < 10) begin
            // noise, with stray last marks
            len = $urandom_range(1, 20);
            for (int i = 0; i < len; i++)
               push_byte(8'($urandom), (i == len - 1) || ($urandom_range(0, 15) == 0));
            items_sent += len;
         end else begin
            if (kind < 20)
               len = $urandom_range(7, 30);
            else
               len = $urandom_range(31, 36);
            build_random_adv(len);
            if (kind >= 20 && kind < 35) begin
               k = $urandom_range(0, 6);
               adv_buf[k] = 8'($urandom);
            end else if (kind >= 35 && kind < 42) begin
               adv_buf[3] = 8'($urandom_range(0, 255));
            end
            send_adv();
            items_sent += len;
         end
      end
   endtask

   initial begin
      req_bus.valid     = 1'b0;
      req_bus.ad_byte   = '0;
      req_bus.last_byte = 1'b0;
      rsp_bus.ready     = 1'b0;
      csr_wr_en         = 1'b0;
      csr_wr_data       = '0;
      send_gaps_on      = 1'b0;
      recv_gaps_on      = 1'b0;
      results_seen      = 0;
      fail_count        = 0;
      frame_id          = MFR_ID_RESET;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_sensor_readings();
      test_header_checks();
      test_length_limits();
      test_company_id();
      test_random_traffic();

      wait_idle();
      if (fail_count == 0 && expected_results.size() == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

endmodule
